// File: design/gsd_pkg.sv
// shared constants and types for the giop stream deframer
package gsd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned MAGIC_LEN  = 4;
    localparam int unsigned HEADER_LEN = 12;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [POS_W-1:0]  pos_t;

    // magic "GIOP"
    localparam byte_t MAGIC [MAGIC_LEN] = '{8'h47, 8'h49, 8'h4F, 8'h50};

    // header byte positions
    localparam pos_t POS_VER_MAJOR = 4'd4;
    localparam pos_t POS_VER_MINOR = 4'd5;
    localparam pos_t POS_FLAGS     = 4'd6;
    localparam pos_t POS_TYPE      = 4'd7;
    localparam pos_t POS_LEN_FIRST = 4'd8;
    localparam pos_t POS_LEN_LAST  = 4'd11;

    // result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

endpackage

// File: design/gsd_stream_if.sv
// valid/ready channel interfaces for received bytes and deframed results
interface gsd_byte_if
    import gsd_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gsd_msg_if
    import gsd_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  item_kind;
    byte_t payload_byte;
    byte_t message_type;
    len_t  message_length;
    logic  is_little_endian;
    byte_t version_major;
    byte_t version_minor;
    logic  last_of_message;

    modport source (
        output valid, output item_kind, output payload_byte, output message_type,
        output message_length, output is_little_endian, output version_major,
        output version_minor, output last_of_message, input ready
    );
    modport sink (
        input valid, input item_kind, input payload_byte, input message_type,
        input message_length, input is_little_endian, input version_major,
        input version_minor, input last_of_message, output ready
    );
endinterface

// File: design/giop_stream_deframer.sv
// giop stream deframer top level: byte stream in, header and payload items out
//
// usage
//   rx  : one received byte per item, valid/ready, accepted when both are high
//   msg : one result item per header or payload byte, valid/ready
//   while hunting, bytes are dropped until "GIOP" arrives in a row; the next
//   eight bytes (version, flags, type, length) produce no item until the
//   twelfth header byte, which yields one header item; each payload byte
//   then yields one payload item, the final one flagged last_of_message.
//   a zero length flags the header item as last. hunting then resumes.
// latency and throughput
//   one byte per cycle sustained while msg.ready is high; an accepted byte's
//   result is shown on msg the cycle after acceptance, from the output register
//   the whole per-byte parse step is combinational logic ahead of that register
// reset
//   rst_n low clears the parser to hunting and empties the output register
// stall
//   while msg.ready is low and a result is held, rx.ready drops; a byte is
//   taken in the same cycle as the held result leaves, so there is no bubble
module giop_stream_deframer
    import gsd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    gsd_byte_if.sink  rx,
    gsd_msg_if.source msg
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // parser state
    phase_t phase_reg, phase_next;
    pos_t   pos_reg, pos_next;
    byte_t  ver_major_reg, ver_major_next;
    byte_t  ver_minor_reg, ver_minor_next;
    logic   endian_reg, endian_next;
    byte_t  type_reg, type_next;
    len_t   length_reg, length_next;
    len_t   remain_reg, remain_next;

    // output register
    logic   out_valid_reg, out_valid_next;
    logic   kind_reg, kind_next;
    byte_t  pbyte_reg, pbyte_next;
    logic   last_reg, last_next;

    logic   accept;
    logic   emit;
    pos_t   pos_inc;
    logic [1:0] magic_idx;
    len_t   byte_ext;

    // take a byte whenever the output register is free or draining
    assign rx.ready = !out_valid_reg || msg.ready;
    assign accept   = rx.valid && rx.ready;

    assign pos_inc   = pos_reg + 4'd1;
    assign magic_idx = pos_reg[1:0];
    assign byte_ext  = {{(LEN_W-BYTE_W){1'b0}}, rx.rx_byte};

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        ver_major_next = ver_major_reg;
        ver_minor_next = ver_minor_reg;
        endian_next    = endian_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        remain_next    = remain_reg;
        emit           = 1'b0;
        kind_next      = kind_reg;
        pbyte_next     = pbyte_reg;
        last_next      = last_reg;

        case (phase_reg)
            PH_HEAD:
            begin
                if (pos_reg == POS_VER_MAJOR)
                begin
                    ver_major_next = rx.rx_byte;
                end
                else if (pos_reg == POS_VER_MINOR)
                begin
                    ver_minor_next = rx.rx_byte;
                end
                else if (pos_reg == POS_FLAGS)
                begin
                    endian_next = (rx.rx_byte != '0);
                end
                else if (pos_reg == POS_TYPE)
                begin
                    type_next   = rx.rx_byte;
                    length_next = '0;
                end
                else if (pos_reg >= POS_LEN_FIRST && pos_reg <= POS_LEN_LAST)
                begin
                    if (endian_reg)
                    begin
                        // little endian: byte lands at its own lane
                        length_next = length_reg | (byte_ext << {pos_reg[1:0], 3'b000});
                    end
                    else
                    begin
                        length_next = {length_reg[LEN_W-BYTE_W-1:0], rx.rx_byte};
                    end
                end

                if (pos_reg >= POS_LEN_LAST)
                begin
                    // header complete
                    emit       = 1'b1;
                    kind_next  = KIND_HEADER;
                    pbyte_next = '0;
                    last_next  = (length_next == '0);
                    pos_next   = '0;
                    if (length_next == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next  = PH_BODY;
                        remain_next = length_next;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end

            PH_BODY:
            begin
                emit       = 1'b1;
                kind_next  = KIND_PAYLOAD;
                pbyte_next = rx.rx_byte;
                last_next  = (remain_reg <= 32'd1);
                if (remain_reg <= 32'd1)
                begin
                    remain_next = '0;
                    phase_next  = PH_HUNT;
                    pos_next    = '0;
                end
                else
                begin
                    remain_next = remain_reg - 32'd1;
                end
            end

            default:
            begin
                // hunting, and the unused phase code
                phase_next = PH_HUNT;
                if (rx.rx_byte == MAGIC[magic_idx])
                begin
                    if (magic_idx == 2'(MAGIC_LEN - 1))
                    begin
                        phase_next = PH_HEAD;
                        pos_next   = POS_VER_MAJOR;
                    end
                    else
                    begin
                        pos_next = {2'b00, magic_idx} + 4'd1;
                    end
                end
                else
                begin
                    // a mismatching 'G' restarts the match at one
                    pos_next = (rx.rx_byte == MAGIC[0]) ? 4'd1 : 4'd0;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (msg.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            pos_reg       <= '0;
            ver_major_reg <= '0;
            ver_minor_reg <= '0;
            endian_reg    <= 1'b0;
            type_reg      <= '0;
            length_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                ver_major_reg <= ver_major_next;
                ver_minor_reg <= ver_minor_next;
                endian_reg    <= endian_next;
                type_reg      <= type_next;
                length_reg    <= length_next;
                remain_reg    <= remain_next;
            end
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg  <= kind_next;
            pbyte_reg <= pbyte_next;
            last_reg  <= last_next;
        end
    end

    // held header values are stable while a result waits, since no byte is
    // taken then; they are shown straight from the parser registers
    assign msg.valid            = out_valid_reg;
    assign msg.item_kind        = kind_reg;
    assign msg.payload_byte     = pbyte_reg;
    assign msg.last_of_message  = last_reg;
    assign msg.message_type     = type_reg;
    assign msg.message_length   = length_reg;
    assign msg.is_little_endian = endian_reg;
    assign msg.version_major    = ver_major_reg;
    assign msg.version_minor    = ver_minor_reg;

`ifndef NO_ASSERTIONS
    // every payload byte taken yields a result in the next cycle
    a_body_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_BODY) |=> out_valid_reg)
        else $error("payload byte produced no result");

    // header capture only runs over header byte positions
    a_head_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEAD) |-> (pos_reg >= POS_VER_MAJOR && pos_reg <= POS_LEN_LAST))
        else $error("header position out of range");

    // hunting keeps the magic match count below the magic length
    a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (pos_reg < 4'(MAGIC_LEN)))
        else $error("magic match count out of range");

    // the payload phase always has bytes still to come
    a_body_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (remain_reg != '0))
        else $error("payload phase with nothing remaining");

    // a last payload result returns the parser to hunting
    a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_BODY && remain_reg <= 32'd1) |=> (phase_reg == PH_HUNT))
        else $error("parser did not resume hunting after last byte");
`endif

endmodule

// File: test/giop_stream_deframer_tb.sv
// self-checking testbench for the giop stream deframer: byte stream in, results checked in order
module giop_stream_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsd_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PHASE_BUDGET   = 460;
    localparam int SETTLE_CYCLES  = 8;

    // one result item as the msg channel shows it
    typedef struct packed {
        logic  kind;
        byte_t data;
        byte_t mtype;
        len_t  mlen;
        logic  le_flag;
        byte_t ver_major;
        byte_t ver_minor;
        logic  last;
    } msg_rec_t;

    // where the parser stands in the byte stream
    typedef enum logic [1:0] {
        SCAN_MAGIC,
        TAKE_HEADER,
        TAKE_PAYLOAD
    } parse_phase_t;

    logic clk;
    logic rst_n;

    gsd_byte_if rx_ch();
    gsd_msg_if  msg_ch();

    giop_stream_deframer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .msg   (msg_ch)
    );

    // free running clock
    initial clk = 1'b0;
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // parser copy kept by the testbench
    parse_phase_t phase_q;
    pos_t         pos_q;
    byte_t        hdr_major;
    byte_t        hdr_minor;
    byte_t        hdr_type;
    logic         hdr_le;
    len_t         hdr_len;
    len_t         body_left;

    // results still owed by the block, oldest first
    msg_rec_t pending_results[$];

    // run bookkeeping
    int errors;
    int bytes_sent;
    int header_results;
    int payload_results;
    int messages_closed;

    // idle mix of the current phase, in percent of cycles
    int src_idle_pct;
    int snk_stall_pct;

    // cycles left in a forced receiver hold-off, counted down by the receiver
    int hold_left;

    int quiet_cycles;

    // -----------------------------------------------------------------
    // prediction
    // -----------------------------------------------------------------

    function automatic msg_rec_t make_result(input logic kind, input byte_t data,
                                             input logic last);
        msg_rec_t rec;
        rec.kind      = kind;
        rec.data      = data;
        rec.mtype     = hdr_type;
        rec.mlen      = hdr_len;
        rec.le_flag   = hdr_le;
        rec.ver_major = hdr_major;
        rec.ver_minor = hdr_minor;
        rec.last      = last;
        return rec;
    endfunction

    // advance the parser copy by one accepted byte; returns 1 when a result is due
    function automatic bit deframe_byte(input byte_t b, output msg_rec_t rec);
        bit   produced;
        logic last;
        produced = 1'b0;
        rec      = '0;
        case (phase_q)
            TAKE_HEADER:
            begin
                case (pos_q)
                    POS_VER_MAJOR: hdr_major = b;
                    POS_VER_MINOR: hdr_minor = b;
                    POS_FLAGS:     hdr_le    = (b != '0);
                    POS_TYPE:
                    begin
                        hdr_type = b;
                        hdr_len  = '0;
                    end
                    default:
                    begin
                        // length bytes: little endian fills from the bottom up
                        if (hdr_le)
                            hdr_len = hdr_len | (len_t'(b) << (8 * (pos_q - POS_LEN_FIRST)));
                        else
                            hdr_len = {hdr_len[LEN_W-BYTE_W-1:0], b};
                    end
                endcase
                if (pos_q == POS_LEN_LAST)
                begin
                    // header complete; a zero length closes the message here
                    last     = (hdr_len == '0);
                    rec      = make_result(KIND_HEADER, '0, last);
                    produced = 1'b1;
                    pos_q    = '0;
                    if (last)
                        phase_q = SCAN_MAGIC;
                    else
                    begin
                        phase_q   = TAKE_PAYLOAD;
                        body_left = hdr_len;
                    end
                end
                else
                    pos_q = pos_q + pos_t'(1);
            end
            TAKE_PAYLOAD:
            begin
                last     = (body_left <= 1);
                rec      = make_result(KIND_PAYLOAD, b, last);
                produced = 1'b1;
                if (body_left != '0)
                    body_left = body_left - len_t'(1);
                if (last)
                begin
                    body_left = '0;
                    phase_q   = SCAN_MAGIC;
                    pos_q     = '0;
                end
            end
            default:
            begin
                // magic hunt: a mismatching first magic byte restarts the match at one
                phase_q = SCAN_MAGIC;
                if (b == MAGIC[pos_q[1:0]])
                begin
                    if (pos_q[1:0] == MAGIC_LEN - 1)
                    begin
                        phase_q = TAKE_HEADER;
                        pos_q   = POS_VER_MAJOR;
                    end
                    else
                        pos_q = pos_q + pos_t'(1);
                end
                else
                    pos_q = (b == MAGIC[0]) ? pos_t'(1) : pos_t'(0);
            end
        endcase
        return produced;
    endfunction

    // -----------------------------------------------------------------
    // result side: check every accepted result, then pick the next ready
    // -----------------------------------------------------------------

    task automatic check_field(input string name, input logic [LEN_W-1:0] want_v,
                               input logic [LEN_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        msg_rec_t want;
        msg_rec_t got;
        if (rst_n)
        begin
            if (msg_ch.valid && msg_ch.ready)
            begin
                got.kind      = msg_ch.item_kind;
                got.data      = msg_ch.payload_byte;
                got.mtype     = msg_ch.message_type;
                got.mlen      = msg_ch.message_length;
                got.le_flag   = msg_ch.is_little_endian;
                got.ver_major = msg_ch.version_major;
                got.ver_minor = msg_ch.version_minor;
                got.last      = msg_ch.last_of_message;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, kind %0h byte %0h last %0h",
                             $time, got.kind, got.data, got.last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("item_kind", len_t'(want.kind), len_t'(got.kind));
                    check_field("payload_byte", len_t'(want.data), len_t'(got.data));
                    check_field("message_type", len_t'(want.mtype), len_t'(got.mtype));
                    check_field("message_length", want.mlen, got.mlen);
                    check_field("is_little_endian", len_t'(want.le_flag),
                                len_t'(got.le_flag));
                    check_field("version_major", len_t'(want.ver_major),
                                len_t'(got.ver_major));
                    check_field("version_minor", len_t'(want.ver_minor),
                                len_t'(got.ver_minor));
                    check_field("last_of_message", len_t'(want.last), len_t'(got.last));
                    if (want.kind == KIND_HEADER)
                        header_results++;
                    else
                        payload_results++;
                    if (want.last)
                        messages_closed++;
                end
            end
            // forced hold-off wins over the random stall mix
            if (hold_left > 0)
            begin
                msg_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                msg_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // watchdog: ends the run after too many cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (msg_ch.valid && msg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // -----------------------------------------------------------------
    // byte side
    // -----------------------------------------------------------------

    // offer one byte, hold it until taken, then record what it should cause;
    // valid is lowered only by the idle gap and by wait_drained, so back to back items keep it high
    task automatic send_byte(input byte_t b);
        msg_rec_t rec;
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= byte_t'($urandom);
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (deframe_byte(b, rec))
            pending_results.push_back(rec);
    endtask

    // magic, header in the byte order the flag selects, then body_n payload bytes
    task automatic send_message(input byte_t ver_major, input byte_t ver_minor,
                                input byte_t flag, input byte_t mtype, input len_t len,
                                input int body_n);
        for (int i = 0; i < MAGIC_LEN; i++)
            send_byte(MAGIC[i]);
        send_byte(ver_major);
        send_byte(ver_minor);
        send_byte(flag);
        send_byte(mtype);
        for (int i = 0; i < 4; i++)
            send_byte((flag != '0) ? len[8*i +: 8] : len[8*(3-i) +: 8]);
        for (int i = 0; i < body_n; i++)
            send_byte(byte_t'($urandom));
    endtask

    // sender steps back until every owed result has been taken
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // -----------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------

    // extremes of the header fields, restart on a stray first magic byte,
    // a broken magic, a zero length message and a one byte little endian message
    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_byte(MAGIC[0]);
        send_message(8'hFF, 8'h00, 8'h00, 8'hFF, '0, 0);
        send_byte(MAGIC[0]);
        send_byte(MAGIC[1]);
        send_byte(8'h00);
        send_message(8'h00, 8'hFF, 8'h80, 8'h00, len_t'(1), 1);
        wait_drained();
    endtask

    // mostly well formed messages with random headers and bodies, mixed with
    // loose noise and magic sequences cut short
    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input int budget);
        int    start_count;
        int    pick;
        int    cut;
        byte_t flag;
        byte_t junk;
        len_t  len;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                repeat ($urandom_range(1, 4))
                    send_byte(byte_t'($urandom));
            else if (pick < 20)
            begin
                // partial magic followed by a byte that cannot complete it
                cut = $urandom_range(1, MAGIC_LEN - 1);
                for (int k = 0; k < cut; k++)
                    send_byte(MAGIC[k]);
                junk = byte_t'($urandom);
                while (junk == MAGIC[cut])
                    junk = byte_t'($urandom);
                send_byte(junk);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    len = '0;
                else if (pick < 85)
                    len = len_t'($urandom_range(1, 12));
                else
                    len = len_t'($urandom_range(13, 48));
                flag = $urandom_range(1) ? byte_t'(0) : byte_t'($urandom_range(1, 255));
                send_message(byte_t'($urandom), byte_t'($urandom), flag,
                             byte_t'($urandom), len, int'(len));
            end
        end
        wait_drained();
    endtask

    // receiver holds off long enough that the block fills and stalls rx
    task automatic test_receiver_hold_off();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_left     = HOLD_OFF_LEN;
        send_message(byte_t'($urandom), byte_t'($urandom), 8'h01, byte_t'($urandom),
                     len_t'(40), 40);
        wait_drained();
    endtask

    // all-ones length: only the start of the body is sent, so this runs last
    task automatic test_max_length();
        src_idle_pct  = 25;
        snk_stall_pct = 25;
        send_message(8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, 16);
        wait_drained();
    endtask

    // -----------------------------------------------------------------
    // sequence
    // -----------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = '0;
        msg_ch.ready    = 1'b0;
        errors          = 0;
        bytes_sent      = 0;
        header_results  = 0;
        payload_results = 0;
        messages_closed = 0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        phase_q         = SCAN_MAGIC;
        pos_q           = '0;
        hdr_major       = '0;
        hdr_minor       = '0;
        hdr_type        = '0;
        hdr_le          = 1'b0;
        hdr_len         = '0;
        body_left       = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(0, 0, PHASE_BUDGET);
        test_random_traffic(49, 0, PHASE_BUDGET);
        test_random_traffic(0, 49, PHASE_BUDGET);
        test_random_traffic(25, 25, PHASE_BUDGET);
        test_receiver_hold_off();
        test_max_length();

        // let anything stray come out before judging
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d bytes: %0d header and %0d payload results, %0d closed messages",
                 bytes_sent, header_results, payload_results, messages_closed);
        $display("idle mixes none/sender/receiver/both, one long receiver hold, drain pauses");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
